/* src/mcps_pkg.sv */
package mcps_pkg;

   // Angle fraction bits and the number of CORDIC rotations that are run.
   localparam int FRAC_BITS     = 8;
   localparam int CORDIC_STAGES = 24;

   localparam int FIELD_W    = 24;
   localparam int GUARD_BITS = 8;
   localparam int ANGLE_Q    = 24;
   localparam int TABLE_SIZE = 32;
   localparam int SHIFT_W    = $clog2(TABLE_SIZE);
   localparam int RUN_STAGES = (CORDIC_STAGES < TABLE_SIZE) ? CORDIC_STAGES : TABLE_SIZE;

   // Datapath widths. The difference is 25 bits, shifted left by the guard bits;
   // the CORDIC gain and the diagonal case add less than two more bits.
   localparam int DIFF_W = FIELD_W + 1;
   localparam int XW     = DIFF_W + GUARD_BITS + 3;
   localparam int ZW     = 35;

   // Gain correction 1/K in Q24, applied as two partial products.
   localparam int GAIN_W = 24;
   localparam logic [GAIN_W-1:0] INV_GAIN = 24'd10188014;
   localparam int LO_W   = 17;
   localparam int HI_W   = XW - 1 - LO_W;
   localparam int PLO_W  = LO_W + GAIN_W;
   localparam int PHI_W  = HI_W + GAIN_W;
   localparam int PROD_W = XW - 1 + GAIN_W + 1;
   localparam int RAD_SHIFT = GUARD_BITS + ANGLE_Q + 1;
   localparam int RAD_W  = 24;
   localparam int ANGLE_W = 16;
   localparam int PRIN_W  = 26;

   localparam logic signed [ZW-1:0] DEG180 = 35'sd3019898880;
   localparam logic signed [ZW-1:0] ANG_LIM = ZW'(90) <<< FRAC_BITS;
   localparam logic signed [ANGLE_W-1:0] ANG_LIM16 = ANGLE_W'(90 << FRAC_BITS);

   typedef struct packed {
      logic                     valid;
      logic                     axis;      // shear is zero: radius and angle are exact
      logic                     neg_dx;    // sx < sy
      logic signed [FIELD_W-1:0] avg;
      logic [RAD_W-1:0]         axis_rad;
      logic signed [XW-1:0]     x;
      logic signed [XW-1:0]     y;
      logic signed [ZW-1:0]     z;
   } cell_type;

   // Arctangent of 2^-i in degrees, Q24.
   function automatic logic signed [ZW-1:0] atan_deg(input logic [SHIFT_W-1:0] idx);
      logic signed [ZW-1:0] val;
      case (idx)
         5'd0:  val = 35'sd754974720;
         5'd1:  val = 35'sd445687602;
         5'd2:  val = 35'sd235489088;
         5'd3:  val = 35'sd119537938;
         5'd4:  val = 35'sd60000934;
         5'd5:  val = 35'sd30029717;
         5'd6:  val = 35'sd15018523;
         5'd7:  val = 35'sd7509720;
         5'd8:  val = 35'sd3754917;
         5'd9:  val = 35'sd1877466;
         5'd10: val = 35'sd938734;
         5'd11: val = 35'sd469367;
         5'd12: val = 35'sd234684;
         5'd13: val = 35'sd117342;
         5'd14: val = 35'sd58671;
         5'd15: val = 35'sd29335;
         5'd16: val = 35'sd14668;
         5'd17: val = 35'sd7334;
         5'd18: val = 35'sd3667;
         5'd19: val = 35'sd1833;
         5'd20: val = 35'sd917;
         5'd21: val = 35'sd458;
         5'd22: val = 35'sd229;
         5'd23: val = 35'sd115;
         5'd24: val = 35'sd57;
         5'd25: val = 35'sd29;
         5'd26: val = 35'sd14;
         5'd27: val = 35'sd7;
         5'd28: val = 35'sd4;
         5'd29: val = 35'sd2;
         5'd30: val = 35'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* src/mcps_cell.sv */
module mcps_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic [mcps_pkg::SHIFT_W-1:0]    stage_shift,
   input  mcps_pkg::cell_type              cell_in,
   output mcps_pkg::cell_type              cell_out
);

   logic                         valid_ff;
   mcps_pkg::cell_type           data_ff;
   mcps_pkg::cell_type           data_in;
   logic signed [mcps_pkg::XW-1:0] x_shift;
   logic signed [mcps_pkg::XW-1:0] y_shift;
   logic signed [mcps_pkg::ZW-1:0] step_angle;

   // One micro-rotation: drive y toward zero and track the angle turned.
   always_comb begin
      x_shift    = cell_in.x >>> stage_shift;
      y_shift    = cell_in.y >>> stage_shift;
      step_angle = mcps_pkg::atan_deg(stage_shift);
      data_in    = cell_in;
      if (!cell_in.y[mcps_pkg::XW-1]) begin
         data_in.x = cell_in.x + y_shift;
         data_in.y = cell_in.y - x_shift;
         data_in.z = cell_in.z + step_angle;
      end else begin
         data_in.x = cell_in.x - y_shift;
         data_in.y = cell_in.y + x_shift;
         data_in.z = cell_in.z - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

/* src/mcps_finish.sv */
module mcps_finish (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  mcps_pkg::cell_type                     cell_in,
   output logic                                   rsp_valid,
   output logic signed [mcps_pkg::FIELD_W-1:0]    rsp_average_stress,
   output logic [mcps_pkg::RAD_W-1:0]             rsp_circle_radius,
   output logic signed [mcps_pkg::PRIN_W-1:0]     rsp_max_principal,
   output logic signed [mcps_pkg::PRIN_W-1:0]     rsp_min_principal,
   output logic signed [mcps_pkg::ANGLE_W-1:0]    rsp_angle_deg
);

   // Stage A: partial products of the gain correction and the rounded angle.
   logic                                   a_valid_ff;
   logic                                   a_axis_ff;
   logic signed [mcps_pkg::FIELD_W-1:0]    a_avg_ff;
   logic [mcps_pkg::RAD_W-1:0]             a_axis_rad_ff;
   logic [mcps_pkg::PLO_W-1:0]             a_plo_ff;
   logic [mcps_pkg::PHI_W-1:0]             a_phi_ff;
   logic signed [mcps_pkg::ANGLE_W-1:0]    a_angle_ff;
   logic [mcps_pkg::PLO_W-1:0]             a_plo_in;
   logic [mcps_pkg::PHI_W-1:0]             a_phi_in;
   logic signed [mcps_pkg::ANGLE_W-1:0]    a_angle_in;
   logic [mcps_pkg::XW-2:0]                x_clip;
   logic signed [mcps_pkg::ZW-1:0]         z_round;

   // Stage B: radius after rounding and saturation.
   logic                                   b_valid_ff;
   logic signed [mcps_pkg::FIELD_W-1:0]    b_avg_ff;
   logic [mcps_pkg::RAD_W-1:0]             b_radius_ff;
   logic signed [mcps_pkg::ANGLE_W-1:0]    b_angle_ff;
   logic [mcps_pkg::RAD_W-1:0]             b_radius_in;
   logic [mcps_pkg::PROD_W-1:0]            prod_sum;

   // Output register.
   logic                                   out_valid_ff;
   logic signed [mcps_pkg::FIELD_W-1:0]    out_avg_ff;
   logic [mcps_pkg::RAD_W-1:0]             out_radius_ff;
   logic signed [mcps_pkg::PRIN_W-1:0]     out_max_ff;
   logic signed [mcps_pkg::PRIN_W-1:0]     out_min_ff;
   logic signed [mcps_pkg::ANGLE_W-1:0]    out_angle_ff;
   logic signed [mcps_pkg::PRIN_W-1:0]     out_max_in;
   logic signed [mcps_pkg::PRIN_W-1:0]     out_min_in;

   always_comb begin
      x_clip   = cell_in.x[mcps_pkg::XW-1] ? '0 : cell_in.x[mcps_pkg::XW-2:0];
      a_plo_in = mcps_pkg::PLO_W'(x_clip[mcps_pkg::LO_W-1:0]) *
                 mcps_pkg::PLO_W'(mcps_pkg::INV_GAIN);
      a_phi_in = mcps_pkg::PHI_W'(x_clip[mcps_pkg::XW-2:mcps_pkg::LO_W]) *
                 mcps_pkg::PHI_W'(mcps_pkg::INV_GAIN);

      z_round = (cell_in.z + (mcps_pkg::ZW'(1) <<< (mcps_pkg::ANGLE_Q - mcps_pkg::FRAC_BITS)))
                >>> (mcps_pkg::ANGLE_Q + 1 - mcps_pkg::FRAC_BITS);
      if (cell_in.axis) begin
         a_angle_in = cell_in.neg_dx ? mcps_pkg::ANGLE_W'(mcps_pkg::ANG_LIM) : '0;
      end else if (z_round > mcps_pkg::ANG_LIM) begin
         a_angle_in = mcps_pkg::ANGLE_W'(mcps_pkg::ANG_LIM);
      end else if (z_round < -mcps_pkg::ANG_LIM) begin
         a_angle_in = mcps_pkg::ANGLE_W'(-mcps_pkg::ANG_LIM);
      end else begin
         a_angle_in = mcps_pkg::ANGLE_W'(z_round);
      end
   end

   always_comb begin
      prod_sum = (mcps_pkg::PROD_W'(a_phi_ff) << mcps_pkg::LO_W) + mcps_pkg::PROD_W'(a_plo_ff)
                 + (mcps_pkg::PROD_W'(1) << (mcps_pkg::RAD_SHIFT - 1));
      if (a_axis_ff) begin
         b_radius_in = a_axis_rad_ff;
      end else if (|prod_sum[mcps_pkg::PROD_W-1:mcps_pkg::RAD_SHIFT+mcps_pkg::RAD_W]) begin
         b_radius_in = '1;
      end else begin
         b_radius_in = prod_sum[mcps_pkg::RAD_SHIFT+mcps_pkg::RAD_W-1:mcps_pkg::RAD_SHIFT];
      end
   end

   always_comb begin
      out_max_in = mcps_pkg::PRIN_W'(b_avg_ff) + $signed({2'b00, b_radius_ff});
      out_min_in = mcps_pkg::PRIN_W'(b_avg_ff) - $signed({2'b00, b_radius_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff   <= cell_in.valid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_axis_ff     <= cell_in.axis;
         a_avg_ff      <= cell_in.avg;
         a_axis_rad_ff <= cell_in.axis_rad;
         a_plo_ff      <= a_plo_in;
         a_phi_ff      <= a_phi_in;
         a_angle_ff    <= a_angle_in;
         b_avg_ff      <= a_avg_ff;
         b_radius_ff   <= b_radius_in;
         b_angle_ff    <= a_angle_ff;
         out_avg_ff    <= b_avg_ff;
         out_radius_ff <= b_radius_ff;
         out_max_ff    <= out_max_in;
         out_min_ff    <= out_min_in;
         out_angle_ff  <= b_angle_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_average_stress = out_avg_ff;
   assign rsp_circle_radius  = out_radius_ff;
   assign rsp_max_principal  = out_max_ff;
   assign rsp_min_principal  = out_min_ff;
   assign rsp_angle_deg      = out_angle_ff;

endmodule

/* src/mohr_circle_principal_stress.sv */
// Mohr's circle for one 2-D stress state per transfer.
//
// The request channel (req_valid, req_stall) carries normal_x, normal_y and
// shear_xy, all signed Q15.8. The response channel (rsp_valid, rsp_stall)
// returns the circle center, the radius (maximum shear), both principal
// stresses and the principal plane angle in degrees, Q7.8.
// Every request transfer produces exactly one response transfer, in order.
// From the request transfer to rsp_valid, a state passes the input register,
// which loads at the transfer edge, then one cell per CORDIC rotation (24
// cells), gain correction in two stages and the output register.
// Throughput is one transfer per cycle unless the receiver stalls; the CORDIC
// cells are fully unrolled, so each works on a different stress state.
// The whole pipeline advances whenever the output register is empty or its
// contents are being taken. When the receiver stalls while a response is
// held, the pipeline freezes and req_stall is raised in the same cycle, so
// nothing is lost; the held response does not change.
// Reset clears all valid bits at once; there is no clearing pass and the
// block is ready on the first cycle after reset.
module mohr_circle_principal_stress (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mcps_pkg::FIELD_W-1:0]    req_normal_x,
   input  logic signed [mcps_pkg::FIELD_W-1:0]    req_normal_y,
   input  logic signed [mcps_pkg::FIELD_W-1:0]    req_shear_xy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mcps_pkg::FIELD_W-1:0]    rsp_average_stress,
   output logic [mcps_pkg::RAD_W-1:0]             rsp_circle_radius,
   output logic signed [mcps_pkg::PRIN_W-1:0]     rsp_max_principal,
   output logic signed [mcps_pkg::PRIN_W-1:0]     rsp_min_principal,
   output logic signed [mcps_pkg::ANGLE_W-1:0]    rsp_angle_deg
);

   logic                                 enable;
   logic signed [mcps_pkg::DIFF_W-1:0]   diff_x;
   logic signed [mcps_pkg::DIFF_W-1:0]   diff_y;
   logic signed [mcps_pkg::DIFF_W-1:0]   sum_xy;
   logic [mcps_pkg::DIFF_W-1:0]          diff_abs;
   logic signed [mcps_pkg::XW-1:0]       x_scaled;
   logic signed [mcps_pkg::XW-1:0]       y_scaled;
   logic                                 prep_valid_ff;
   mcps_pkg::cell_type                   prep_ff;
   mcps_pkg::cell_type                   prep_in;
   mcps_pkg::cell_type                   chain [0:mcps_pkg::RUN_STAGES];

   // The whole pipeline moves together; the output register is the only
   // place a finished result can wait.
   assign enable    = !rsp_valid || !rsp_stall;
   assign req_stall = !enable;

   // Input preparation: center, difference vector, and the half-turn that
   // brings a vector in the left half plane over to the right.
   always_comb begin
      sum_xy   = mcps_pkg::DIFF_W'(req_normal_x) + mcps_pkg::DIFF_W'(req_normal_y);
      diff_x   = mcps_pkg::DIFF_W'(req_normal_x) - mcps_pkg::DIFF_W'(req_normal_y);
      diff_y   = {req_shear_xy, 1'b0};
      diff_abs = diff_x[mcps_pkg::DIFF_W-1] ? mcps_pkg::DIFF_W'(-diff_x) : diff_x;
      x_scaled = mcps_pkg::XW'(diff_x) <<< mcps_pkg::GUARD_BITS;
      y_scaled = mcps_pkg::XW'(diff_y) <<< mcps_pkg::GUARD_BITS;

      prep_in          = '0;
      prep_in.valid    = 1'b1;
      prep_in.axis     = (req_shear_xy == '0);
      prep_in.neg_dx   = diff_x[mcps_pkg::DIFF_W-1];
      prep_in.avg      = sum_xy[mcps_pkg::DIFF_W-1:1];
      // On the x axis the radius is half the difference, rounded up.
      prep_in.axis_rad = mcps_pkg::RAD_W'(({1'b0, diff_abs} + 1'b1) >> 1);
      if (diff_x[mcps_pkg::DIFF_W-1]) begin
         prep_in.x = -x_scaled;
         prep_in.y = -y_scaled;
         prep_in.z = diff_y[mcps_pkg::DIFF_W-1] ? -mcps_pkg::DEG180 : mcps_pkg::DEG180;
      end else begin
         prep_in.x = x_scaled;
         prep_in.y = y_scaled;
         prep_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (enable) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prep_ff <= prep_in;
      end
   end

   always_comb begin
      chain[0]       = prep_ff;
      chain[0].valid = prep_valid_ff;
   end

   // Row of CORDIC vectoring cells, one rotation each.
   for (genvar i = 0; i < mcps_pkg::RUN_STAGES; i++) begin : g_cell
      mcps_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .stage_shift (mcps_pkg::SHIFT_W'(i)),
         .cell_in     (chain[i]),
         .cell_out    (chain[i+1])
      );
   end

   mcps_finish u_finish (
      .clock              (clock),
      .reset              (reset),
      .enable             (enable),
      .cell_in            (chain[mcps_pkg::RUN_STAGES]),
      .rsp_valid          (rsp_valid),
      .rsp_average_stress (rsp_average_stress),
      .rsp_circle_radius  (rsp_circle_radius),
      .rsp_max_principal  (rsp_max_principal),
      .rsp_min_principal  (rsp_min_principal),
      .rsp_angle_deg      (rsp_angle_deg)
   );

   // The two principal stresses always lie one diameter apart.
   a_diameter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mcps_pkg::PRIN_W'(rsp_max_principal - rsp_min_principal)
                     == {1'b0, rsp_circle_radius, 1'b0}))
      else $error("principal stresses are not one diameter apart");

   // The angle is clamped to plus or minus 90 degrees.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_deg <= mcps_pkg::ANG_LIM16 &&
                     rsp_angle_deg >= -mcps_pkg::ANG_LIM16))
      else $error("principal angle out of range");

   // With no result waiting, a request is never held off.
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output register is empty");

   // Nothing comes out in the first cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

/* tb/mohr_result_checker.sv */
`timescale 1ns / 1ps

module mohr_result_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [mcps_pkg::FIELD_W-1:0] req_normal_x,
   input  logic signed [mcps_pkg::FIELD_W-1:0] req_normal_y,
   input  logic signed [mcps_pkg::FIELD_W-1:0] req_shear_xy,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [mcps_pkg::FIELD_W-1:0] rsp_average_stress,
   input  logic [mcps_pkg::RAD_W-1:0]          rsp_circle_radius,
   input  logic signed [mcps_pkg::PRIN_W-1:0]  rsp_max_principal,
   input  logic signed [mcps_pkg::PRIN_W-1:0]  rsp_min_principal,
   input  logic signed [mcps_pkg::ANGLE_W-1:0] rsp_angle_deg,
   output int                                  outstanding,
   output int                                  results_checked,
   output int                                  mismatch_count
);

   typedef struct packed {
      logic signed [mcps_pkg::FIELD_W-1:0] avg;
      logic [mcps_pkg::RAD_W-1:0]          radius;
      logic signed [mcps_pkg::PRIN_W-1:0]  p_max;
      logic signed [mcps_pkg::PRIN_W-1:0]  p_min;
      logic signed [mcps_pkg::ANGLE_W-1:0] angle;
   } mohr_circle_type;

   // Arctangent of 2^-i in degrees, Q24.
   localparam longint ATAN_DEG_Q24 [32] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934, 30029717, 15018523, 7509720,
      3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335,
      14668, 7334, 3667, 1833,
      917, 458, 229, 115,
      57, 29, 14, 7,
      4, 2, 1, 0
   };
   localparam longint GAIN_RECIP_Q24 = 10188014;
   localparam longint HALF_TURN_Q24  = 64'sd3019898880;
   localparam longint RADIUS_MAX     = 64'sh0FF_FFFF;
   localparam int     ROTATIONS      = (mcps_pkg::CORDIC_STAGES < 32) ?
                                       mcps_pkg::CORDIC_STAGES : 32;

   mohr_circle_type expected_circles[$];
   mohr_circle_type want;
   int              mismatches = 0;
   int              checked_total = 0;

   assign results_checked = checked_total;
   assign mismatch_count  = mismatches;

   function automatic mohr_circle_type predict_mohr_circle(
      input logic signed [mcps_pkg::FIELD_W-1:0] nx,
      input logic signed [mcps_pkg::FIELD_W-1:0] ny,
      input logic signed [mcps_pkg::FIELD_W-1:0] sh
   );
      longint          sx, sy, txy, avg, dx, dy, mag;
      longint          x, y, z, xs, ys, radius, ang, lim;
      longint          p_hi, p_lo;
      int              i;
      mohr_circle_type r;
      sx  = nx;
      sy  = ny;
      txy = sh;
      avg = (sx + sy) >>> 1;
      dx  = sx - sy;
      dy  = 2 * txy;
      lim = longint'(90) << mcps_pkg::FRAC_BITS;
      if (dy == 0) begin
         // Stress along the axes only: radius and angle are exact.
         mag    = (dx < 0) ? -dx : dx;
         radius = (mag + 1) >>> 1;
         ang    = (dx < 0) ? lim : 0;
      end else begin
         x = dx * 256;
         y = dy * 256;
         z = 0;
         // Left half plane: turn by half a circle toward the side of the shear.
         if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
            x = -x;
            y = -y;
         end
         for (i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_DEG_Q24[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_DEG_Q24[i];
            end
         end
         if (x < 0)
            x = 0;
         radius = (x * GAIN_RECIP_Q24 + 64'sd4294967296) >>> 33;
         if (radius > RADIUS_MAX)
            radius = RADIUS_MAX;
         ang = (z + (longint'(1) << (24 - mcps_pkg::FRAC_BITS)))
               >>> (25 - mcps_pkg::FRAC_BITS);
         if (ang > lim)
            ang = lim;
         if (ang < -lim)
            ang = -lim;
      end
      p_hi     = avg + radius;
      p_lo     = avg - radius;
      r.avg    = avg[mcps_pkg::FIELD_W-1:0];
      r.radius = radius[mcps_pkg::RAD_W-1:0];
      r.p_max  = p_hi[mcps_pkg::PRIN_W-1:0];
      r.p_min  = p_lo[mcps_pkg::PRIN_W-1:0];
      r.angle  = ang[mcps_pkg::ANGLE_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_circles.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_circles.size() == 0) begin
               report_mismatch($sformatf("response transfer with nothing expected, center %0d",
                                         rsp_average_stress));
            end else begin
               want = expected_circles.pop_front();
               if (rsp_average_stress !== want.avg)
                  report_mismatch($sformatf("result %0d average_stress %0d, expected %0d",
                                            checked_total, rsp_average_stress, want.avg));
               if (rsp_circle_radius !== want.radius)
                  report_mismatch($sformatf("result %0d circle_radius %0d, expected %0d",
                                            checked_total, rsp_circle_radius, want.radius));
               if (rsp_max_principal !== want.p_max)
                  report_mismatch($sformatf("result %0d max_principal %0d, expected %0d",
                                            checked_total, rsp_max_principal, want.p_max));
               if (rsp_min_principal !== want.p_min)
                  report_mismatch($sformatf("result %0d min_principal %0d, expected %0d",
                                            checked_total, rsp_min_principal, want.p_min));
               if (rsp_angle_deg !== want.angle)
                  report_mismatch($sformatf("result %0d angle_deg %0d, expected %0d",
                                            checked_total, rsp_angle_deg, want.angle));
               checked_total++;
            end
         end
         if (req_valid && !req_stall)
            expected_circles.push_back(predict_mohr_circle(req_normal_x, req_normal_y,
                                                           req_shear_xy));
         outstanding <= expected_circles.size();
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Top level of the Mohr's circle testbench. This module only produces
// stimulus and states the verdict; the checker beside the block watches both
// channels, predicts every response and compares it field by field.
module tb;

   localparam logic signed [mcps_pkg::FIELD_W-1:0] FIELD_MAX = 24'sh7FFFFF;
   localparam logic signed [mcps_pkg::FIELD_W-1:0] FIELD_MIN = 24'sh800000;
   localparam int RANDOM_ITEMS   = 650;
   // Cycles without any transfer before the run is declared hung. This leaves
   // a wide margin over the pipeline latency and the usual receiver stalls.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;

   // Receiver behaviors; one is picked at random each time the low seven bits of stall_cycle are zero.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid    = 1'b0;
   logic                                req_stall;
   logic signed [mcps_pkg::FIELD_W-1:0] req_normal_x = '0;
   logic signed [mcps_pkg::FIELD_W-1:0] req_normal_y = '0;
   logic signed [mcps_pkg::FIELD_W-1:0] req_shear_xy = '0;
   logic                                rsp_valid;
   logic                                rsp_stall    = 1'b0;
   logic signed [mcps_pkg::FIELD_W-1:0] rsp_average_stress;
   logic [mcps_pkg::RAD_W-1:0]          rsp_circle_radius;
   logic signed [mcps_pkg::PRIN_W-1:0]  rsp_max_principal;
   logic signed [mcps_pkg::PRIN_W-1:0]  rsp_min_principal;
   logic signed [mcps_pkg::ANGLE_W-1:0] rsp_angle_deg;

   int outstanding;
   int results_checked;
   int mismatch_count;

   int              items_sent    = 0;
   int              burst_left    = 0;
   int              idle_cycles   = 0;
   int              held_cycles   = 0;
   logic [15:0]     stall_cycle   = '0;
   stall_style_type stall_style   = STALL_NONE;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   mohr_circle_principal_stress u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_normal_x       (req_normal_x),
      .req_normal_y       (req_normal_y),
      .req_shear_xy       (req_shear_xy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_average_stress (rsp_average_stress),
      .rsp_circle_radius  (rsp_circle_radius),
      .rsp_max_principal  (rsp_max_principal),
      .rsp_min_principal  (rsp_min_principal),
      .rsp_angle_deg      (rsp_angle_deg)
   );

   mohr_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_normal_x       (req_normal_x),
      .req_normal_y       (req_normal_y),
      .req_shear_xy       (req_shear_xy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_average_stress (rsp_average_stress),
      .rsp_circle_radius  (rsp_circle_radius),
      .rsp_max_principal  (rsp_max_principal),
      .rsp_min_principal  (rsp_min_principal),
      .rsp_angle_deg      (rsp_angle_deg),
      .outstanding        (outstanding),
      .results_checked    (results_checked),
      .mismatch_count     (mismatch_count)
   );

   // The receiver switches between never stalling, random stalls, a fixed
   // one-in-four pattern and long stretches of stalling. The heavy style
   // backs the pipeline up so that req_stall gets exercised as well.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle <= '0;
         stall_style <= STALL_NONE;
      end else begin
         stall_cycle <= stall_cycle + 1'b1;
         if (stall_cycle[6:0] == 7'd0)
            stall_style <= stall_style_type'($urandom_range(0, 3));
         case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: rsp_stall <= (stall_cycle[1:0] == 2'd3);
            default:        rsp_stall <= ($urandom_range(0, 99) < 85);
         endcase
         if (rsp_valid && rsp_stall)
            held_cycles <= held_cycles + 1;
      end
   end

   // Any transfer on either channel restarts the count. If the block stops
   // moving altogether, the run ends here as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles, %0d responses still due",
                     idle_cycles, outstanding);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Offer one stress state and wait for its transfer. Items go out in bursts
   // of random length; between bursts the sender usually drops valid. Valid is
   // only lowered and raised at different clock edges.
   task automatic send_stress(input logic signed [mcps_pkg::FIELD_W-1:0] nx,
                              input logic signed [mcps_pkg::FIELD_W-1:0] ny,
                              input logic signed [mcps_pkg::FIELD_W-1:0] sh);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_shear_xy <= sh;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
   endtask

   // Stop sending until every response that is due has been checked. The
   // first wait lets the count pick up the transfer made at this edge.
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      burst_left = 0;
   endtask

   function automatic logic signed [mcps_pkg::FIELD_W-1:0] pick_corner_value();
      case ($urandom_range(0, 5))
         0:       return FIELD_MAX;
         1:       return FIELD_MIN;
         2:       return '0;
         3:       return -24'sd1;
         4:       return 24'sd1;
         default: return mcps_pkg::FIELD_W'($urandom());
      endcase
   endfunction

   // Most states are fully random across the whole field range. The rest
   // lean on the special cases: zero shear, equal normal stresses, small
   // magnitudes near the origin and combinations of the field limits.
   task automatic random_stress(output logic signed [mcps_pkg::FIELD_W-1:0] nx,
                                output logic signed [mcps_pkg::FIELD_W-1:0] ny,
                                output logic signed [mcps_pkg::FIELD_W-1:0] sh);
      int pick;
      pick = $urandom_range(0, 99);
      nx = mcps_pkg::FIELD_W'($urandom());
      ny = mcps_pkg::FIELD_W'($urandom());
      sh = mcps_pkg::FIELD_W'($urandom());
      if (pick < 55) begin
         // Leave the full-range draw as it is.
      end else if (pick < 70) begin
         sh = '0;
      end else if (pick < 80) begin
         ny = nx;
      end else if (pick < 90) begin
         nx = mcps_pkg::FIELD_W'($signed($urandom_range(0, 4000)) - 2000);
         ny = mcps_pkg::FIELD_W'($signed($urandom_range(0, 4000)) - 2000);
         sh = mcps_pkg::FIELD_W'($signed($urandom_range(0, 4000)) - 2000);
      end else begin
         nx = pick_corner_value();
         ny = pick_corner_value();
         sh = pick_corner_value();
      end
   endtask

   initial begin
      logic signed [mcps_pkg::FIELD_W-1:0] nx, ny, sh;
      int n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed states. The zero vector and equal normal stresses give a
      // zero radius; pure normal differences hit the exact axis path with
      // both odd and even differences and both angle results (0 and +90).
      send_stress(0, 0, 0);
      send_stress(100, 100, 0);
      send_stress(1000, -500, 0);
      send_stress(-500, 1000, 0);
      send_stress(1, 0, 0);
      send_stress(0, 1, 0);
      send_stress(-1, 0, 0);
      send_stress(-1, -1, 1);
      // Pure shear, both signs.
      send_stress(0, 0, 256);
      send_stress(0, 0, -256);
      // Left half plane, with the half turn going each way, then two states in the right half plane.
      send_stress(-300, 700, 400);
      send_stress(-300, 700, -400);
      send_stress(500, -200, 300);
      send_stress(1000, 0, 500);
      // Field limits, including the largest possible radius.
      send_stress(FIELD_MAX, FIELD_MAX, FIELD_MAX);
      send_stress(FIELD_MIN, FIELD_MIN, FIELD_MIN);
      send_stress(FIELD_MAX, FIELD_MIN, 0);
      send_stress(FIELD_MIN, FIELD_MAX, 0);
      send_stress(FIELD_MAX, FIELD_MIN, FIELD_MAX);
      send_stress(FIELD_MIN, FIELD_MAX, FIELD_MIN);
      send_stress(FIELD_MIN, FIELD_MAX, FIELD_MAX);
      send_stress(FIELD_MAX, FIELD_MIN, FIELD_MIN);
      send_stress(0, 0, FIELD_MIN);
      send_stress(0, 0, FIELD_MAX);
      drain_results();

      // Random part. Halfway through, the sender waits for the pipeline to
      // empty completely before carrying on.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            drain_results();
         random_stress(nx, ny, sh);
         send_stress(nx, ny, sh);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      // Any response beyond the expected ones would show up here.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d stress states including the axis, shear and field-limit cases;",
               items_sent);
      $display("checked %0d responses, %0d cycles with a response held by the receiver.",
               results_checked, held_cycles);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* mohr_circle_principal_stress.f */
src/mcps_pkg.sv
src/mcps_cell.sv
src/mcps_finish.sv
src/mohr_circle_principal_stress.sv
tb/mohr_result_checker.sv
tb/tb.sv
